/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on the rising clock edge, off while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// ante holds in a cycle -> cons holds in the same cycle
`define NBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nbd assertion failed");
// ante holds in a cycle -> cons holds in the next cycle
`define NBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nbd assertion failed");
`else
`define NBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define NBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* sv/nbd_pkg.sv */
// ---------------------------------------------------------------------------
// nbd_pkg
// Types, sizes and codes shared by the noise burst detector modules.
// ---------------------------------------------------------------------------
package nbd_pkg;

	localparam int LEVEL_DEPTH = 16;
	localparam int EVENT_DEPTH = 4;

	localparam int LVL_AW  = $clog2(LEVEL_DEPTH);
	localparam int EVT_AW  = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
	localparam int LIVE_W  = $clog2(EVENT_DEPTH + 1);
	localparam int LEN_W   = $clog2(LEVEL_DEPTH + 1);
	localparam int SPAN_W  = $clog2(2 * LEVEL_DEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [11:0] LEVEL_FULL = 12'd4095;
	localparam logic        KIND_TICK  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [11:0] reading;
	} in_word_t;

	typedef struct packed {
		logic detected;
		logic noise_on;
		logic noise_off;
		logic led;
	} out_word_t;

	typedef struct packed {
		logic        enable;
		logic [11:0] level_threshold;
		logic [4:0]  run_length;
		logic [2:0]  event_count_limit;
		logic [31:0] expiry_ms;
		logic [15:0] short_hold_ms;
		logic [15:0] long_hold_ms;
	} cfg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE      = 3'd0,
		REG_LEVEL_THR   = 3'd1,
		REG_RUN_LENGTH  = 3'd2,
		REG_EVENT_LIMIT = 3'd3,
		REG_EXPIRY      = 3'd4,
		REG_SHORT_HOLD  = 3'd5,
		REG_LONG_HOLD   = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TICK,
		ST_WRITE,
		ST_SCAN,
		ST_LOG,
		ST_EXPIRE,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_item;
		logic do_tick;
		logic ring_write;
		logic scan_step;
		logic log_event;
		logic expire_step;
		logic decide;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic item_kind;
		logic enable;
		logic scan_hit;
		logic scan_last;
		logic expire_last;
		logic out_free;
	} status_t;

endpackage

/* sv/nbd_ctrl.sv */
// ---------------------------------------------------------------------------
// nbd_ctrl
// Sequencer: walks one word through decode, tick or ring write and scan, event log, expiry walk, decision and output.
// ---------------------------------------------------------------------------
module nbd_ctrl import nbd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.item_kind == KIND_TICK) begin
					state_d = ST_TICK;
				end else if (status.enable) begin
					state_d = ST_WRITE;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_TICK: begin
				cmd.do_tick = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_WRITE: begin
				cmd.ring_write = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_hit) begin
					state_d = ST_LOG;
				end else if (status.scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_LOG: begin
				cmd.log_event = 1'b1;
				state_d       = ST_EXPIRE;
			end
			ST_EXPIRE: begin
				cmd.expire_step = 1'b1;
				if (status.expire_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/nbd_datapath.sv */
// ---------------------------------------------------------------------------
// nbd_datapath
// Level ring, run scanner, event log, hold timers and output register.
// ---------------------------------------------------------------------------
module nbd_datapath import nbd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  in_word_t  in_data,
	input  cmd_t      cmd,
	output status_t   status,
	input  logic      out_ready,
	output logic      out_valid,
	output out_word_t out_data
);

	in_word_t item_q;

	logic [11:0]       ring_q [LEVEL_DEPTH];
	logic [LVL_AW-1:0] wpos_q;
	logic [LVL_AW-1:0] sidx_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [SPAN_W-1:0] rem_q;

	logic [31:0]            times_q [EVENT_DEPTH];
	logic [EVENT_DEPTH-1:0] evalid_q;
	logic [EVT_AW-1:0]      ewpos_q;
	logic [EVT_AW-1:0]      eidx_q;
	logic [LIVE_W-1:0]      live_q;

	logic [31:0] now_q;
	logic [15:0] short_left_q;
	logic [15:0] long_left_q;
	logic        led_q;
	logic        det_q;
	logic        on_q;
	logic        off_q;

	logic        out_valid_q;
	out_word_t   out_q;

	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  len_m1;
	logic [LVL_AW-1:0] scan_start;
	logic [SPAN_W-1:0] span_m1;
	logic [LEN_W-1:0]  cnt_inc;
	logic              qual;
	logic              hit;
	logic [31:0]       age;
	logic              stale;
	logic              out_free;

	// clamp run length to 1..LEVEL_DEPTH
	always_comb begin
		if (cfg.run_length == '0) begin
			len = LEN_W'(1);
		end else if (int'(cfg.run_length) > LEVEL_DEPTH) begin
			len = LEN_W'(LEVEL_DEPTH);
		end else begin
			len = LEN_W'(cfg.run_length);
		end
		len_m1 = len - LEN_W'(1);
		// scan starts len-1 entries before slot 0, wrapping
		if (len_m1 == '0) begin
			scan_start = '0;
		end else begin
			scan_start = LVL_AW'(LEVEL_DEPTH - int'(len_m1));
		end
		span_m1 = SPAN_W'(int'(len_m1) + LEVEL_DEPTH - 1);
	end

	assign qual    = (ring_q[sidx_q] >= cfg.level_threshold);
	assign cnt_inc = cnt_q + LEN_W'(1);
	assign hit     = qual && (cnt_inc >= len);

	assign age   = now_q - times_q[eidx_q];
	assign stale = evalid_q[eidx_q] && (age > cfg.expiry_ms);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		status.item_kind   = item_q.kind;
		status.enable      = cfg.enable;
		status.scan_hit    = hit;
		status.scan_last   = (rem_q == '0);
		status.expire_last = (eidx_q == EVT_AW'(EVENT_DEPTH - 1));
		status.out_free    = out_free;
	end

	// payload-only registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_data;
		end
		if (cmd.log_event) begin
			times_q[ewpos_q] <= now_q;
		end
		if (cmd.emit) begin
			out_q <= '{detected: det_q, noise_on: on_q, noise_off: off_q, led: led_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVEL_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			wpos_q       <= '0;
			sidx_q       <= '0;
			cnt_q        <= '0;
			rem_q        <= '0;
			evalid_q     <= '0;
			ewpos_q      <= '0;
			eidx_q       <= '0;
			live_q       <= '0;
			now_q        <= '0;
			short_left_q <= '0;
			long_left_q  <= '0;
			led_q        <= 1'b0;
			det_q        <= 1'b0;
			on_q         <= 1'b0;
			off_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				det_q <= 1'b0;
				on_q  <= 1'b0;
				off_q <= 1'b0;
			end

			if (cmd.do_tick) begin
				now_q <= now_q + 32'd1;
				if (short_left_q != '0) begin
					short_left_q <= short_left_q - 16'd1;
					if (short_left_q == 16'd1) begin
						led_q <= 1'b0;
					end
				end
				if (long_left_q != '0) begin
					long_left_q <= long_left_q - 16'd1;
					if (long_left_q == 16'd1) begin
						led_q <= 1'b0;
						off_q <= 1'b1;
					end
				end
			end

			if (cmd.ring_write) begin
				ring_q[wpos_q] <= LEVEL_FULL - item_q.reading;
				if (wpos_q == LVL_AW'(LEVEL_DEPTH - 1)) begin
					wpos_q <= '0;
				end else begin
					wpos_q <= wpos_q + LVL_AW'(1);
				end
				sidx_q <= scan_start;
				cnt_q  <= '0;
				rem_q  <= span_m1;
			end

			if (cmd.scan_step) begin
				if (sidx_q == LVL_AW'(LEVEL_DEPTH - 1)) begin
					sidx_q <= '0;
				end else begin
					sidx_q <= sidx_q + LVL_AW'(1);
				end
				cnt_q <= qual ? cnt_inc : '0;
				rem_q <= rem_q - SPAN_W'(1);
			end

			if (cmd.log_event) begin
				for (int i = 0; i < LEVEL_DEPTH; i++) begin
					ring_q[i] <= '0;
				end
				evalid_q[ewpos_q] <= 1'b1;
				if (ewpos_q == EVT_AW'(EVENT_DEPTH - 1)) begin
					ewpos_q <= '0;
				end else begin
					ewpos_q <= ewpos_q + EVT_AW'(1);
				end
				det_q  <= 1'b1;
				led_q  <= 1'b1;
				eidx_q <= '0;
				live_q <= '0;
			end

			if (cmd.expire_step) begin
				if (stale) begin
					evalid_q[eidx_q] <= 1'b0;
				end else if (evalid_q[eidx_q]) begin
					live_q <= live_q + LIVE_W'(1);
				end
				if (eidx_q != EVT_AW'(EVENT_DEPTH - 1)) begin
					eidx_q <= eidx_q + EVT_AW'(1);
				end
			end

			if (cmd.decide) begin
				if (int'(live_q) >= int'(cfg.event_count_limit)) begin
					evalid_q    <= '0;
					on_q        <= 1'b1;
					long_left_q <= (cfg.long_hold_ms == '0) ? 16'd1 : cfg.long_hold_ms;
				end else begin
					short_left_q <= (cfg.short_hold_ms == '0) ? 16'd1 : cfg.short_hold_ms;
				end
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* sv/noise_burst_detector_top.sv */
// One word at a time: the next word is accepted only after the result word of the last is registered.
// Rate is set by the run scan, which reads one ring entry per cycle, and the walk over the event log.
// Reset (arst_n low, async) clears ring, event valid bits, clock, holds, LED; config to defaults.
// ---------------------------------------------------------------------------
// noise_burst_detector_top
// Noise burst detector: config registers, sequencer and datapath.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module noise_burst_detector_top import nbd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable            <= 1'b0;
			cfg_q.level_threshold   <= 12'd1;
			cfg_q.run_length        <= 5'd2;
			cfg_q.event_count_limit <= 3'd2;
			cfg_q.expiry_ms         <= 32'd60000;
			cfg_q.short_hold_ms     <= 16'd2000;
			cfg_q.long_hold_ms      <= 16'd4000;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ENABLE:      cfg_q.enable            <= cfg_wdata[0];
				REG_LEVEL_THR:   cfg_q.level_threshold   <= cfg_wdata[11:0];
				REG_RUN_LENGTH:  cfg_q.run_length        <= cfg_wdata[4:0];
				REG_EVENT_LIMIT: cfg_q.event_count_limit <= cfg_wdata[2:0];
				REG_EXPIRY:      cfg_q.expiry_ms         <= cfg_wdata[31:0];
				REG_SHORT_HOLD:  cfg_q.short_hold_ms     <= cfg_wdata[15:0];
				REG_LONG_HOLD:   cfg_q.long_hold_ms      <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	nbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	nbd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// one word in flight: no second accept right after one
	`NBD_ASSERT_NEXT(a_single_word, clk, arst_n, in_valid && in_ready, !in_ready)
	// noise on only comes with the detection that caused it
	`NBD_ASSERT_SAME(a_on_needs_det, clk, arst_n, out_valid && out_data.noise_on, out_data.detected)
	// noise off only on ticks, never with a detection
	`NBD_ASSERT_SAME(a_off_not_det, clk, arst_n, out_valid && out_data.noise_off, !out_data.detected)
	// a detection always lights the LED
	`NBD_ASSERT_SAME(a_det_led, clk, arst_n, out_valid && out_data.detected, out_data.led)

endmodule

/* sim/tb_noise_burst_detector_top.sv */
// ---------------------------------------------------------------------------
// tb_noise_burst_detector_top
// Self-checking bench for the noise burst detector. A queue-fed driver sends
// sample and tick words, a shadow of the detector predicts the flags of each
// accepted word, and a monitor compares every result word in order.
// ---------------------------------------------------------------------------
module tb_noise_burst_detector_top;
	import nbd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF    = 5;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 60;
	localparam logic KIND_SAMPLE = ~KIND_TICK;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_word_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	in_word_t  stim_words[$];
	out_word_t pending_flags[$];
	int        fail_count = 0;
	int        quiet_cycles = 0;
	int        in_gap = 0;
	int        out_stall = 0;
	bit        idling_on = 1'b1;

	// shadow of the detector
	cfg_t              cfg_shadow;
	logic [11:0]       lvl_ring [LEVEL_DEPTH];
	logic [LVL_AW-1:0] lvl_pos;
	logic [31:0]       evt_stamp [EVENT_DEPTH];
	logic              evt_live [EVENT_DEPTH];
	logic [EVT_AW-1:0] evt_pos;
	logic [31:0]       ms_now;
	logic [15:0]       short_left;
	logic [15:0]       long_left;
	logic              led_q;

	noise_burst_detector_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic int clamped_run();
		int need;
		need = int'(cfg_shadow.run_length);
		if (need == 0) need = 1;
		if (need > LEVEL_DEPTH) need = LEVEL_DEPTH;
		return need;
	endfunction

	// circular walk in storage order, starting need-1 entries before slot 0
	function automatic bit ring_has_run();
		int need, hits, idx;
		need = clamped_run();
		hits = 0;
		for (int k = 0; k < need - 1 + LEVEL_DEPTH; k++) begin
			idx = (k + LEVEL_DEPTH - (need - 1)) % LEVEL_DEPTH;
			if (lvl_ring[idx] >= cfg_shadow.level_threshold) begin
				hits++;
				if (hits >= need) return 1'b1;
			end else begin
				hits = 0;
			end
		end
		return 1'b0;
	endfunction

	function automatic out_word_t predict_flags(input in_word_t w);
		out_word_t r;
		int alive;
		logic [31:0] age;
		r = '0;
		if (w.kind == KIND_TICK) begin
			ms_now = ms_now + 32'd1;
			if (short_left != 0) begin
				short_left = short_left - 16'd1;
				if (short_left == 0) led_q = 1'b0;
			end
			if (long_left != 0) begin
				long_left = long_left - 16'd1;
				if (long_left == 0) begin
					led_q = 1'b0;
					r.noise_off = 1'b1;
				end
			end
		end else if (cfg_shadow.enable) begin
			lvl_ring[lvl_pos] = LEVEL_FULL - w.reading;
			lvl_pos = lvl_pos + LVL_AW'(1);
			if (ring_has_run()) begin
				r.detected = 1'b1;
				foreach (lvl_ring[k]) lvl_ring[k] = '0;
				evt_stamp[evt_pos] = ms_now;
				evt_live[evt_pos] = 1'b1;
				evt_pos = evt_pos + EVT_AW'(1);
				alive = 0;
				for (int i = 0; i < EVENT_DEPTH; i++) begin
					age = ms_now - evt_stamp[i];
					if (evt_live[i] && age > cfg_shadow.expiry_ms) evt_live[i] = 1'b0;
					if (evt_live[i]) alive++;
				end
				led_q = 1'b1;
				if (alive >= int'(cfg_shadow.event_count_limit)) begin
					foreach (evt_live[k]) evt_live[k] = 1'b0;
					r.noise_on = 1'b1;
					long_left = (cfg_shadow.long_hold_ms == 0) ? 16'd1 : cfg_shadow.long_hold_ms;
				end else begin
					short_left = (cfg_shadow.short_hold_ms == 0) ? 16'd1 : cfg_shadow.short_hold_ms;
				end
			end
		end
		r.led = led_q;
		return r;
	endfunction

	function automatic void clear_predictor();
		cfg_shadow.enable            = 1'b0;
		cfg_shadow.level_threshold   = 12'd1;
		cfg_shadow.run_length        = 5'd2;
		cfg_shadow.event_count_limit = 3'd2;
		cfg_shadow.expiry_ms         = 32'd60000;
		cfg_shadow.short_hold_ms     = 16'd2000;
		cfg_shadow.long_hold_ms      = 16'd4000;
		foreach (lvl_ring[k]) lvl_ring[k] = '0;
		foreach (evt_live[k]) evt_live[k] = 1'b0;
		lvl_pos    = '0;
		evt_pos    = '0;
		ms_now     = '0;
		short_left = '0;
		long_left  = '0;
		led_q      = 1'b0;
	endfunction

	// input side: word source with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_gap != 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (stim_words.size() != 0) begin
				in_data <= stim_words.pop_front();
				in_valid <= 1'b1;
				if (idling_on && $urandom_range(0, 4) == 0)
					in_gap <= $urandom_range(1, 7);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: random stall bursts with out_ready held low
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_stall != 0) begin
			out_stall <= out_stall - 1;
			out_ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			out_stall <= $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// result check first, then prediction for the word taken at this edge
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_flags.size() == 0) begin
					$error("result word %b with nothing expected", out_data);
					fail_count++;
				end else begin
					want = pending_flags.pop_front();
					if (out_data.detected !== want.detected) begin
						$error("detected: expected %0b, got %0b", want.detected, out_data.detected);
						fail_count++;
					end
					if (out_data.noise_on !== want.noise_on) begin
						$error("noise_on: expected %0b, got %0b", want.noise_on, out_data.noise_on);
						fail_count++;
					end
					if (out_data.noise_off !== want.noise_off) begin
						$error("noise_off: expected %0b, got %0b", want.noise_off,
							out_data.noise_off);
						fail_count++;
					end
					if (out_data.led !== want.led) begin
						$error("led: expected %0b, got %0b", want.led, out_data.led);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				pending_flags.push_back(predict_flags(in_data));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("noise_burst_detector_top test failed");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENABLE:      cfg_shadow.enable            = val[0];
			REG_LEVEL_THR:   cfg_shadow.level_threshold   = val[11:0];
			REG_RUN_LENGTH:  cfg_shadow.run_length        = val[4:0];
			REG_EVENT_LIMIT: cfg_shadow.event_count_limit = val[2:0];
			REG_EXPIRY:      cfg_shadow.expiry_ms         = val;
			REG_SHORT_HOLD:  cfg_shadow.short_hold_ms     = val[15:0];
			REG_LONG_HOLD:   cfg_shadow.long_hold_ms      = val[15:0];
			default: ;
		endcase
	endtask

	task automatic setup(input logic [31:0] en, input logic [31:0] thr,
		input logic [31:0] run, input logic [31:0] lim, input logic [31:0] expiry,
		input logic [31:0] short_ms, input logic [31:0] long_ms);
		write_reg(REG_ENABLE, en);
		write_reg(REG_LEVEL_THR, thr);
		write_reg(REG_RUN_LENGTH, run);
		write_reg(REG_EVENT_LIMIT, lim);
		write_reg(REG_EXPIRY, expiry);
		write_reg(REG_SHORT_HOLD, short_ms);
		write_reg(REG_LONG_HOLD, long_ms);
		@(negedge clk);
	endtask

	task automatic push_sample(input int reading);
		in_word_t w;
		w.kind = KIND_SAMPLE;
		w.reading = reading[11:0];
		stim_words.push_back(w);
	endtask

	task automatic push_ticks(input int n);
		in_word_t w;
		repeat (n) begin
			w.kind = KIND_TICK;
			w.reading = 12'($urandom_range(0, 4095));
			stim_words.push_back(w);
		end
	endtask

	// checked at the falling edge, clear of the sampling edge
	task automatic settle();
		do @(negedge clk);
		while (stim_words.size() != 0 || in_valid || pending_flags.size() != 0);
	endtask

	task automatic random_setup();
		logic [31:0] thr, run, lim, expiry, short_ms, long_ms;
		thr = $urandom_range(0, 4095);
		run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
		lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3);
		case ($urandom_range(0, 5))
			0: expiry = 32'hFFFF_FFFF;
			1: expiry = $urandom();
			default: expiry = $urandom_range(0, 40);
		endcase
		short_ms = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
		long_ms  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
		setup(32'($urandom_range(0, 7) != 0), thr, run, lim, expiry, short_ms, long_ms);
	endtask

	// qualifying runs of about the needed length, mixed with ticks and noise
	task automatic fill_phase(input int goal);
		int made, need, n, thr;
		made = 0;
		need = clamped_run();
		thr = int'(cfg_shadow.level_threshold);
		while (made < goal) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					n = $urandom_range(1, 8);
					push_ticks(n);
					made += n;
				end
				3, 4, 5, 6: begin
					n = need + $urandom_range(0, 2) - 1;
					if (n < 1) n = 1;
					repeat (n) push_sample($urandom_range(0, 4095 - thr));
					if (cfg_shadow.enable) made += n;
				end
				7, 8: begin
					if (thr == 0) push_sample($urandom_range(0, 4095));
					else push_sample($urandom_range(4096 - thr, 4095));
					if (cfg_shadow.enable) made++;
				end
				default: begin
					push_sample($urandom_range(0, 4095));
					if (cfg_shadow.enable) made++;
				end
			endcase
		end
	endtask

	initial begin
		clear_predictor();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: detector disabled, samples ignored
		push_sample(0);
		push_sample(4095);
		push_ticks(1);
		settle();

		// top threshold, zero run length, zero limit, zero holds
		setup(1, 4095, 0, 0, 0, 0, 0);
		push_sample(0);
		push_ticks(1);
		push_sample(4095);
		push_sample(1);
		settle();

		// zero threshold, run above depth, limit never reached, retriggered short hold
		setup(1, 0, 31, 7, 32'hFFFF_FFFF, 3, 65535);
		push_sample(4095);
		push_sample(2048);
		push_sample(0);
		push_ticks(2);
		push_sample(1234);
		push_ticks(3);
		settle();

		// short hold ends while the long hold runs
		setup(1, 4095, 1, 2, 0, 2, 5);
		push_sample(0);
		push_sample(0);
		push_ticks(5);
		settle();

		for (int phase = 0; phase < 12; phase++) begin
			if (phase >= 10) idling_on = 1'b0;
			random_setup();
			fill_phase(58);
			settle();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("noise_burst_detector_top test passed");
		else
			$display("noise_burst_detector_top test failed");
		$finish;
	end

endmodule
